// ===== hw/rtl/ptru_pkg.sv =====
// Shared types, constants and helpers for the point translate/rotate unit.
package ptru_pkg;

   localparam int COORD_W      = 32;
   localparam int ANGLE_W      = 16;
   localparam int GUARD_BITS   = 8;
   localparam int CORDIC_STEPS = 16;
   localparam int MAX_STEPS    = 30;
   localparam int STEP_COUNT   = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
   localparam int STEP_W       = $clog2(MAX_STEPS);
   localparam int WORK_W       = 43;                      // Q16.24 plus CORDIC growth
   localparam int SUM_W        = WORK_W - GUARD_BITS;     // pre-saturation width
   localparam int RESID_W      = 32;                      // angle, 2^32 per turn

   // command and axis codes
   localparam logic [1:0] CMD_SET       = 2'd0;
   localparam logic [1:0] CMD_TRANSLATE = 2'd1;
   localparam logic [1:0] CMD_ROTATE    = 2'd2;
   localparam logic [1:0] AXIS_X        = 2'd0;
   localparam logic [1:0] AXIS_Y        = 2'd1;

   typedef struct packed {
      logic                      start;
      logic [COORD_W-1:0]        a;
      logic [COORD_W-1:0]        b;
      logic [ANGLE_W-1:0]        angle;
   } rot_req_type;

   typedef struct packed {
      logic                      done;
      logic                      clip;
      logic [COORD_W-1:0]        a;
      logic [COORD_W-1:0]        b;
   } rot_rsp_type;

   typedef struct packed {
      logic                      clip;
      logic [COORD_W-1:0]        value;
   } sat_type;

   // atan(2^-i) in 2^32-per-turn units
   function automatic logic signed [RESID_W-1:0] atan_step(input logic [STEP_W-1:0] i);
      logic signed [RESID_W-1:0] r;
      case (i)
         5'd0:  r = 32'sd536870912;
         5'd1:  r = 32'sd316933406;
         5'd2:  r = 32'sd167458907;
         5'd3:  r = 32'sd85004756;
         5'd4:  r = 32'sd42667331;
         5'd5:  r = 32'sd21354465;
         5'd6:  r = 32'sd10679838;
         5'd7:  r = 32'sd5340245;
         5'd8:  r = 32'sd2670163;
         5'd9:  r = 32'sd1335087;
         5'd10: r = 32'sd667544;
         5'd11: r = 32'sd333772;
         5'd12: r = 32'sd166886;
         5'd13: r = 32'sd83443;
         5'd14: r = 32'sd41722;
         5'd15: r = 32'sd20861;
         5'd16: r = 32'sd10430;
         5'd17: r = 32'sd5215;
         5'd18: r = 32'sd2608;
         5'd19: r = 32'sd1304;
         5'd20: r = 32'sd652;
         5'd21: r = 32'sd326;
         5'd22: r = 32'sd163;
         5'd23: r = 32'sd81;
         5'd24: r = 32'sd41;
         5'd25: r = 32'sd20;
         5'd26: r = 32'sd10;
         5'd27: r = 32'sd5;
         5'd28: r = 32'sd3;
         5'd29: r = 32'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // clip a wide signed value into a 32-bit coordinate
   function automatic sat_type sat_coord(input logic signed [SUM_W-1:0] v);
      sat_type r;
      logic    fits;
      fits = (v[SUM_W-1:COORD_W-1] == '0) || (v[SUM_W-1:COORD_W-1] == '1);
      r.clip = !fits;
      if (fits) begin
         r.value = v[COORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         r.value = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r.value = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/point_translate_rotate_unit.sv =====
// Top level of the point translate/rotate unit.
//
// Holds one 3D point in signed Q16.16 and applies one command per request:
// set, translate, or rotate about x, y or z (axis code 3 also means z) by a
// 16-bit binary angle (65536 = one turn). Every request returns the new
// point and a saturation flag. Set, translate and the unused command pass
// from acceptance through the result registers and the write-back state.
// A rotate passes through the gain-correction multiplier (a, then b), a
// rounding step, a quarter-turn fix-up, CORDIC_STEPS micro-rotations on
// the shared shift-add unit, a final round and saturate, a hand-off into
// the result registers, and the write-back.
// req_tready is high only while the unit is idle; a finished result can
// still sit unread on the response side while the next request is accepted,
// and write-back of that next request waits until the response register is
// free.
module point_translate_rotate_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,   // arg_x, arg_y, arg_z, turn_angle
   input  logic [3:0]    req_tuser,   // cmd, axis_code
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata,   // pos_x, pos_y, pos_z
   output logic [0:0]    rsp_tuser    // saturated
);

   localparam int CW = ptru_pkg::COORD_W;
   localparam int SW = ptru_pkg::SUM_W;

   typedef enum logic [1:0] {ST_IDLE, ST_ROTATE, ST_WRITE} state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    point_x_ff, point_x_in, point_y_ff, point_y_in;
   logic [CW-1:0]    point_z_ff, point_z_in;
   logic [CW-1:0]    res_x_ff, res_x_in, res_y_ff, res_y_in, res_z_ff, res_z_in;
   logic             res_sat_ff, res_sat_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_sat_ff, rsp_sat_in;
   logic [1:0]       axis_ff, axis_in;

   // request fields
   logic [1:0]                    req_cmd, req_axis;
   logic [CW-1:0]                 arg_x, arg_y, arg_z;
   logic [ptru_pkg::ANGLE_W-1:0]  turn_angle;
   logic                          req_fire;

   ptru_pkg::rot_req_type  rot_req;
   ptru_pkg::rot_rsp_type  rot_rsp;
   ptru_pkg::sat_type      sum_x, sum_y, sum_z;

   assign req_cmd    = req_tuser[1:0];
   assign req_axis   = req_tuser[3:2];
   assign arg_x      = req_tdata[31:0];
   assign arg_y      = req_tdata[63:32];
   assign arg_z      = req_tdata[95:64];
   assign turn_angle = req_tdata[111:96];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;

   // translate: widen, add, clip
   assign sum_x = ptru_pkg::sat_coord({{(SW-CW){point_x_ff[CW-1]}}, point_x_ff}
                                    + {{(SW-CW){arg_x[CW-1]}}, arg_x});
   assign sum_y = ptru_pkg::sat_coord({{(SW-CW){point_y_ff[CW-1]}}, point_y_ff}
                                    + {{(SW-CW){arg_y[CW-1]}}, arg_y});
   assign sum_z = ptru_pkg::sat_coord({{(SW-CW){point_z_ff[CW-1]}}, point_z_ff}
                                    + {{(SW-CW){arg_z[CW-1]}}, arg_z});

   // rotation pair: x -> (y,z), y -> (z,x), z -> (x,y)
   always_comb begin
      rot_req.start = req_fire && (req_cmd == ptru_pkg::CMD_ROTATE);
      rot_req.angle = turn_angle;
      unique case (req_axis)
         ptru_pkg::AXIS_X: begin
            rot_req.a = point_y_ff;
            rot_req.b = point_z_ff;
         end
         ptru_pkg::AXIS_Y: begin
            rot_req.a = point_z_ff;
            rot_req.b = point_x_ff;
         end
         default: begin
            rot_req.a = point_x_ff;
            rot_req.b = point_y_ff;
         end
      endcase
   end

   ptru_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .rot_req (rot_req),
      .rot_rsp (rot_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      point_x_in   = point_x_ff;
      point_y_in   = point_y_ff;
      point_z_in   = point_z_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_z_in     = res_z_ff;
      res_sat_in   = res_sat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_sat_in   = rsp_sat_ff;
      axis_in      = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               axis_in    = req_axis;
               res_x_in   = point_x_ff;
               res_y_in   = point_y_ff;
               res_z_in   = point_z_ff;
               res_sat_in = 1'b0;
               state_in   = ST_WRITE;
               case (req_cmd)
                  ptru_pkg::CMD_SET: begin
                     res_x_in = arg_x;
                     res_y_in = arg_y;
                     res_z_in = arg_z;
                  end
                  ptru_pkg::CMD_TRANSLATE: begin
                     res_x_in   = sum_x.value;
                     res_y_in   = sum_y.value;
                     res_z_in   = sum_z.value;
                     res_sat_in = sum_x.clip | sum_y.clip | sum_z.clip;
                  end
                  ptru_pkg::CMD_ROTATE: state_in = ST_ROTATE;
                  default: ;   // unused command: point unchanged
               endcase
            end
         end
         ST_ROTATE: begin
            if (rot_rsp.done) begin
               res_sat_in = rot_rsp.clip;
               unique case (axis_ff)
                  ptru_pkg::AXIS_X: begin
                     res_y_in = rot_rsp.a;
                     res_z_in = rot_rsp.b;
                  end
                  ptru_pkg::AXIS_Y: begin
                     res_z_in = rot_rsp.a;
                     res_x_in = rot_rsp.b;
                  end
                  default: begin
                     res_x_in = rot_rsp.a;
                     res_y_in = rot_rsp.b;
                  end
               endcase
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // the response shows the point register, so commit only when free
            if (!rsp_valid_ff || rsp_tready) begin
               point_x_in   = res_x_ff;
               point_y_in   = res_y_ff;
               point_z_in   = res_z_ff;
               rsp_sat_in   = res_sat_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         point_x_ff   <= '0;
         point_y_ff   <= '0;
         point_z_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         point_x_ff   <= point_x_in;
         point_y_ff   <= point_y_in;
         point_z_ff   <= point_z_in;
      end
      res_x_ff   <= res_x_in;
      res_y_ff   <= res_y_in;
      res_z_ff   <= res_z_in;
      res_sat_ff <= res_sat_in;
      rsp_sat_ff <= rsp_sat_in;
      axis_ff    <= axis_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {point_z_ff, point_y_ff, point_x_ff};
   assign rsp_tuser  = rsp_sat_ff;

endmodule

// ===== hw/rtl/ptru_cordic.sv =====
// Gain-corrected CORDIC rotation of one coordinate pair on a shared shift-add unit.
module ptru_cordic (
   input  logic                  clock,
   input  logic                  reset,
   input  ptru_pkg::rot_req_type rot_req,
   output ptru_pkg::rot_rsp_type rot_rsp
);

   localparam int PROD_W = 2 * ptru_pkg::COORD_W + 1;
   localparam int RND_SH = ptru_pkg::COORD_W - ptru_pkg::GUARD_BITS;
   localparam int RND_W  = PROD_W - RND_SH;
   localparam logic signed [ptru_pkg::COORD_W:0] GAIN_Q32 = 33'sh0_9B74EDA8;
   localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (RND_SH - 1);
   localparam logic signed [ptru_pkg::WORK_W-1:0] OUT_HALF =
      ptru_pkg::WORK_W'(1) << (ptru_pkg::GUARD_BITS - 1);
   localparam logic [ptru_pkg::STEP_W-1:0] LAST_STEP =
      ptru_pkg::STEP_W'(ptru_pkg::STEP_COUNT - 1);

   typedef enum logic [2:0] {
      CS_IDLE, CS_MUL_A, CS_MUL_B, CS_RND_B, CS_QUAD, CS_ITER, CS_FINISH
   } cstate_type;

   cstate_type                                 state_ff, state_in;
   logic signed [ptru_pkg::COORD_W-1:0]        op_a_ff, op_a_in, op_b_ff, op_b_in;
   logic [1:0]                                 quad_ff, quad_in;
   logic signed [ptru_pkg::RESID_W-1:0]        resid_ff, resid_in;
   logic signed [PROD_W-1:0]                   prod_ff, prod_in;
   logic signed [ptru_pkg::WORK_W-1:0]         wa_ff, wa_in, wb_ff, wb_in;
   logic [ptru_pkg::STEP_W-1:0]                step_ff, step_in;
   logic                                       done_ff, done_in, clip_ff, clip_in;
   logic [ptru_pkg::COORD_W-1:0]               out_a_ff, out_a_in, out_b_ff, out_b_in;

   logic signed [ptru_pkg::COORD_W-1:0]        mul_op;
   logic signed [PROD_W-1:0]                   mul_res;
   logic signed [PROD_W-1:0]                   rnd_sum;
   logic signed [ptru_pkg::WORK_W-1:0]         rnd_val;
   logic signed [ptru_pkg::WORK_W-1:0]         da, db;
   logic signed [ptru_pkg::WORK_W-1:0]         fin_a, fin_b;
   logic [ptru_pkg::ANGLE_W-1:0]               ang_sum, ang_res;
   ptru_pkg::sat_type                          sat_a, sat_b;

   // angle reduction: nearest quarter turn plus signed residual
   assign ang_sum = rot_req.angle + ptru_pkg::ANGLE_W'(16'd8192);
   assign ang_res = rot_req.angle - {ang_sum[15:14], 14'd0};

   // the one multiplier: gain correction, a then b
   assign mul_op  = (state_ff == CS_MUL_A) ? op_a_ff : op_b_ff;
   assign mul_res = mul_op * GAIN_Q32;
   assign rnd_sum = prod_ff + PROD_HALF;
   assign rnd_val = {{(ptru_pkg::WORK_W-RND_W){rnd_sum[PROD_W-1]}},
                     rnd_sum[PROD_W-1:RND_SH]};

   // shift-add unit
   assign da = wb_ff >>> step_ff;
   assign db = wa_ff >>> step_ff;

   assign fin_a = wa_ff + OUT_HALF;
   assign fin_b = wb_ff + OUT_HALF;
   assign sat_a = ptru_pkg::sat_coord(fin_a[ptru_pkg::WORK_W-1:ptru_pkg::GUARD_BITS]);
   assign sat_b = ptru_pkg::sat_coord(fin_b[ptru_pkg::WORK_W-1:ptru_pkg::GUARD_BITS]);

   always_comb begin
      state_in = state_ff;
      op_a_in  = op_a_ff;
      op_b_in  = op_b_ff;
      quad_in  = quad_ff;
      resid_in = resid_ff;
      prod_in  = prod_ff;
      wa_in    = wa_ff;
      wb_in    = wb_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      clip_in  = clip_ff;
      out_a_in = out_a_ff;
      out_b_in = out_b_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (rot_req.start) begin
               op_a_in  = rot_req.a;
               op_b_in  = rot_req.b;
               quad_in  = ang_sum[15:14];
               resid_in = {ang_res, 16'd0};
               state_in = CS_MUL_A;
            end
         end
         CS_MUL_A: begin
            prod_in  = mul_res;
            state_in = CS_MUL_B;
         end
         CS_MUL_B: begin
            wa_in    = rnd_val;
            prod_in  = mul_res;
            state_in = CS_RND_B;
         end
         CS_RND_B: begin
            wb_in    = rnd_val;
            state_in = CS_QUAD;
         end
         CS_QUAD: begin
            case (quad_ff)
               2'd1: begin
                  wa_in = -wb_ff;
                  wb_in = wa_ff;
               end
               2'd2: begin
                  wa_in = -wa_ff;
                  wb_in = -wb_ff;
               end
               2'd3: begin
                  wa_in = wb_ff;
                  wb_in = -wa_ff;
               end
               default: ;
            endcase
            step_in  = '0;
            state_in = CS_ITER;
         end
         CS_ITER: begin
            if (!resid_ff[ptru_pkg::RESID_W-1]) begin
               wa_in    = wa_ff - da;
               wb_in    = wb_ff + db;
               resid_in = resid_ff - ptru_pkg::atan_step(step_ff);
            end else begin
               wa_in    = wa_ff + da;
               wb_in    = wb_ff - db;
               resid_in = resid_ff + ptru_pkg::atan_step(step_ff);
            end
            if (step_ff == LAST_STEP) begin
               state_in = CS_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         CS_FINISH: begin
            out_a_in = sat_a.value;
            out_b_in = sat_b.value;
            clip_in  = sat_a.clip | sat_b.clip;
            done_in  = 1'b1;
            state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_a_ff  <= op_a_in;
      op_b_ff  <= op_b_in;
      quad_ff  <= quad_in;
      resid_ff <= resid_in;
      prod_ff  <= prod_in;
      wa_ff    <= wa_in;
      wb_ff    <= wb_in;
      step_ff  <= step_in;
      clip_ff  <= clip_in;
      out_a_ff <= out_a_in;
      out_b_ff <= out_b_in;
   end

   assign rot_rsp.done = done_ff;
   assign rot_rsp.clip = clip_ff;
   assign rot_rsp.a    = out_a_ff;
   assign rot_rsp.b    = out_b_ff;

endmodule
